// ----- src/daily_dose_alarm_scheduler_core_macros.svh -----
// assertion macros for the daily dose alarm scheduler core
// included by files that carry concurrent checks
`ifndef DAILY_DOSE_ALARM_SCHEDULER_CORE_MACROS_SVH
`define DAILY_DOSE_ALARM_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DDAS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DDAS_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DDAS_ASSERT(label, clk, rst, prop)
`define DDAS_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- src/ddas_pkg.sv -----
// shared types and constants for the daily dose alarm scheduler
// no dependencies
package ddas_pkg;
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_SLOT  = 2'd1;
   localparam logic [1:0] ACT_PUMP  = 2'd2;
   localparam logic [1:0] ACT_QUERY = 2'd3;
   localparam logic [31:0] GUARD_MS = 32'd3000;
   localparam logic [16:0] DAY_SECONDS = 17'd86400;
   localparam logic [8:0] NEVER_DAY = 9'd511;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  pump;
      logic [2:0]  slot;
      logic [16:0] now_sec;
      logic [8:0]  day_of_year;
      logic [31:0] now_ms;
      logic [16:0] slot_time_in;
      logic [15:0] dose_in;
      logic [15:0] rate_in;
      logic [3:0]  count_in;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  pump_out;
      logic [15:0] run_seconds;
      logic [16:0] next_run_sec;
      logic        none_scheduled;
      logic        last;
   } rsp_type;
endpackage

// ----- src/ddas_front.sv -----
// front end: two-entry input queue ahead of the sequencer
// depends on ddas_pkg
module ddas_front import ddas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output req_type cmd_item
);
   req_type q_ff [2];
   req_type q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic acc, deq;

   assign full = cnt_ff[1];
   assign acc = push && !full;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_item = q_ff[0];
   assign deq = cmd_valid && cmd_take;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, acc} - {1'b0, deq};
      q0_in = q_ff[0];
      q1_in = q_ff[1];
      if (deq) begin
         q0_in = q_ff[1];
      end
      if (acc) begin
         if (cnt_ff - {1'b0, deq} == 2'd0) begin
            q0_in = req_item;
         end else begin
            q1_in = req_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end
endmodule

// ----- src/ddas_back.sv -----
// back end: slot table, tick walk with serial divider, query search, result queue
// depends on ddas_pkg and the macro header
`include "daily_dose_alarm_scheduler_core_macros.svh"
module ddas_back import ddas_pkg::*; #(
   parameter int PUMP_COUNT = 4,
   parameter int SLOTS_PER_PUMP = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  req_type cmd_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);
   localparam int TOTAL = PUMP_COUNT * SLOTS_PER_PUMP;
   localparam int IW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int PW = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;
   localparam int QD = 4;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_QANS  = 3'd5;

   logic [16:0] time_mem [TOTAL];
   logic [15:0] dose_mem [TOTAL];
   logic [8:0]  fday_mem [TOTAL];
   logic [31:0] fms_mem  [TOTAL];
   logic [TOTAL-1:0] tvalid_ff, fvalid_ff;
   logic [15:0] rate_ff [PUMP_COUNT];
   logic [3:0]  count_ff [PUMP_COUNT];

   logic [2:0]  state_ff;
   req_type     cur_ff;
   logic [3:0]  p_ff;
   logic [3:0]  t_ff;
   logic [16:0] rd_time_ff;
   logic [15:0] rd_dose_ff;
   logic [8:0]  rd_day_ff;
   logic [31:0] rd_ms_ff;
   logic        rd_tv_ff, rd_fv_ff;
   logic [16:0] rem_ff;
   logic [15:0] quo_ff;
   logic [4:0]  dcnt_ff;
   logic [15:0] dose_ff;
   logic        found_ff;
   logic [16:0] best_ff, earliest_ff;
   logic        pend_ff;
   rsp_type     pend_item_ff;

   rsp_type     rq_ff [QD];
   logic [1:0]  rh_ff, rt_ff;
   logic [2:0]  rc_ff;

   logic [IW-1:0] idx, widx;
   logic [3:0]    used, cpump;
   logic [15:0]   rate_eff, cdose;
   logic [16:0]   ctime, back;
   logic [17:0]   sub;
   logic [8:0]    cday;
   logic [31:0]   cms;
   logic          gone, fire, qspace, pop_ok, q_push, pump_ok, slot_ok;
   rsp_type       q_item, ans_item;

   function automatic logic [IW-1:0] mk_idx(input logic [3:0] p, input logic [3:0] t);
      logic [31:0] v;
      v = 32'(p) * 32'(SLOTS_PER_PUMP) + 32'(t);
      return v[IW-1:0];
   endfunction

   assign idx = mk_idx(p_ff, t_ff);
   assign cpump = {2'b0, cmd_item.pump};
   assign widx = mk_idx(cpump, {1'b0, cmd_item.slot});
   assign pump_ok = 32'(cmd_item.pump) < PUMP_COUNT;
   assign slot_ok = pump_ok && (32'(cmd_item.slot) < SLOTS_PER_PUMP);
   assign used = (count_ff[p_ff[PW-1:0]] > 4'(SLOTS_PER_PUMP)) ? 4'(SLOTS_PER_PUMP)
                 : count_ff[p_ff[PW-1:0]];
   assign rate_eff = (rate_ff[p_ff[PW-1:0]] == 16'd0) ? 16'd1 : rate_ff[p_ff[PW-1:0]];
   assign ctime = rd_tv_ff ? rd_time_ff : 17'd0;
   assign cdose = rd_tv_ff ? rd_dose_ff : 16'd0;
   assign cday = rd_fv_ff ? rd_day_ff : NEVER_DAY;
   assign cms = rd_fv_ff ? rd_ms_ff : 32'd0;
   assign gone = (cday == cur_ff.day_of_year) && (cur_ff.now_ms - cms < GUARD_MS);
   assign fire = (ctime == cur_ff.now_sec) && !gone;
   assign back = cur_ff.now_sec - earliest_ff;
   assign qspace = rc_ff < 3'(QD);
   assign pop_ok = pop && !empty;
   assign sub = {1'b0, rem_ff[15:0], dose_ff[15]} - {2'b0, rate_eff};

   assign cmd_take = (state_ff == S_IDLE);
   assign empty = rc_ff == 3'd0;
   assign rsp_item = rq_ff[rh_ff];

   always_comb begin
      ans_item = '0;
      ans_item.kind = 1'b1;
      ans_item.pump_out = cur_ff.pump;
      ans_item.last = 1'b1;
      if (32'(cur_ff.pump) >= PUMP_COUNT || t_ff == 4'd0) begin
         ans_item.none_scheduled = 1'b1;
      end else if (found_ff) begin
         ans_item.next_run_sec = best_ff;
      end else if (back < DAY_SECONDS) begin
         ans_item.next_run_sec = DAY_SECONDS - back;
      end
      q_push = 1'b0;
      q_item = pend_item_ff;
      unique case (state_ff)
         S_DIV: q_push = (dcnt_ff == 5'd0) && pend_ff && qspace;
         S_EMIT: begin
            q_push = pend_ff && qspace;
            q_item.last = 1'b1;
         end
         S_QANS: begin
            q_push = qspace;
            q_item = ans_item;
         end
         default: q_push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tvalid_ff <= '0;
         fvalid_ff <= '0;
         pend_ff <= 1'b0;
         rh_ff <= 2'd0;
         rt_ff <= 2'd0;
         rc_ff <= 3'd0;
         for (int i = 0; i < PUMP_COUNT; i++) begin
            rate_ff[i] <= 16'd1;
            count_ff[i] <= 4'd0;
         end
      end else begin
         rc_ff <= rc_ff + {2'b0, q_push} - {2'b0, pop_ok};
         if (pop_ok) rh_ff <= rh_ff + 2'd1;
         if (q_push) begin
            rq_ff[rt_ff] <= q_item;
            rt_ff <= rt_ff + 2'd1;
         end
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cur_ff <= cmd_item;
               p_ff <= (cmd_item.action == ACT_TICK) ? 4'd0 : cpump;
               t_ff <= 4'd0;
               found_ff <= 1'b0;
               best_ff <= 17'd0;
               earliest_ff <= 17'h1FFFF;
               if (cmd_item.action == ACT_TICK || cmd_item.action == ACT_QUERY) begin
                  state_ff <= S_READ;
               end
               if (cmd_item.action == ACT_SLOT && slot_ok) begin
                  time_mem[widx] <= cmd_item.slot_time_in;
                  dose_mem[widx] <= cmd_item.dose_in;
                  tvalid_ff[widx] <= 1'b1;
               end
               if (cmd_item.action == ACT_PUMP && pump_ok) begin
                  rate_ff[cpump[PW-1:0]] <= cmd_item.rate_in;
                  count_ff[cpump[PW-1:0]] <= cmd_item.count_in;
               end
            end
            S_READ: begin
               if (32'(p_ff) >= PUMP_COUNT) begin
                  state_ff <= (cur_ff.action == ACT_QUERY) ? S_QANS : S_EMIT;
               end else if (t_ff >= used) begin
                  if (cur_ff.action == ACT_QUERY) begin
                     state_ff <= S_QANS;
                  end else begin
                     p_ff <= p_ff + 4'd1;
                     t_ff <= 4'd0;
                  end
               end else begin
                  rd_time_ff <= time_mem[idx];
                  rd_dose_ff <= dose_mem[idx];
                  rd_day_ff <= fday_mem[idx];
                  rd_ms_ff <= fms_mem[idx];
                  rd_tv_ff <= tvalid_ff[idx];
                  rd_fv_ff <= fvalid_ff[idx];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (cur_ff.action == ACT_QUERY) begin
                  if (ctime < earliest_ff) earliest_ff <= ctime;
                  if (ctime >= cur_ff.now_sec &&
                      (!found_ff || ctime - cur_ff.now_sec < best_ff)) begin
                     best_ff <= ctime - cur_ff.now_sec;
                     found_ff <= 1'b1;
                  end
                  t_ff <= t_ff + 4'd1;
                  state_ff <= S_READ;
               end else begin
                  if (fire) begin
                     fday_mem[idx] <= cur_ff.day_of_year;
                     fms_mem[idx] <= cur_ff.now_ms;
                     fvalid_ff[idx] <= 1'b1;
                  end
                  if (fire && cdose != 16'd0) begin
                     dose_ff <= cdose;
                     rem_ff <= 17'd0;
                     quo_ff <= 16'd0;
                     dcnt_ff <= 5'd16;
                     state_ff <= S_DIV;
                  end else begin
                     t_ff <= t_ff + 4'd1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_DIV: begin
               if (dcnt_ff != 5'd0) begin
                  dose_ff <= {dose_ff[14:0], 1'b0};
                  if (!sub[17]) begin
                     rem_ff <= sub[16:0];
                     quo_ff <= {quo_ff[14:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[15:0], dose_ff[15]};
                     quo_ff <= {quo_ff[14:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff - 5'd1;
               end else if (!pend_ff || qspace) begin
                  // the previous order leaves for the queue, the new one is held
                  pend_ff <= 1'b1;
                  pend_item_ff.kind <= 1'b0;
                  pend_item_ff.pump_out <= p_ff[1:0];
                  pend_item_ff.run_seconds <= quo_ff + {15'd0, rem_ff != 17'd0};
                  pend_item_ff.next_run_sec <= 17'd0;
                  pend_item_ff.none_scheduled <= 1'b0;
                  pend_item_ff.last <= 1'b0;
                  t_ff <= t_ff + 4'd1;
                  state_ff <= S_READ;
               end
            end
            S_EMIT: begin
               // end of tick walk: the held order goes out as the final one
               if (!pend_ff) begin
                  state_ff <= S_IDLE;
               end else if (qspace) begin
                  pend_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_QANS: if (qspace) begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DDAS_ASSERT(a_rq_bound, clock, reset, rc_ff <= 3'(QD))
   `DDAS_ASSERT(a_no_over, clock, reset, (rc_ff == 3'(QD)) |-> !q_push)
   `DDAS_ASSERT(a_take_idle, clock, reset, cmd_take |-> (state_ff == S_IDLE))
   `DDAS_ASSERT(a_idle_no_hold, clock, reset, (state_ff == S_IDLE) |-> !pend_ff)
endmodule

// ----- src/daily_dose_alarm_scheduler_core.sv -----
// Daily dose alarm scheduler: a two-entry input queue feeds a sequencer that holds the
// slot table and walks it. Set slot and set pump items are done in the idle state. A query
// walks the active slots of its pump. A tick walks the active slots of every pump, and
// each firing slot with a nonzero dose goes through the shared restoring divider.
// Run orders pass through one held register and a four-entry result queue; a full
// queue stalls the walk.
// depends on ddas_pkg, ddas_front, ddas_back
module daily_dose_alarm_scheduler_core import ddas_pkg::*; #(
   parameter int PUMP_COUNT = 4,
   parameter int SLOTS_PER_PUMP = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_pump,
   input  logic [2:0]  req_slot,
   input  logic [16:0] req_now_sec,
   input  logic [8:0]  req_day_of_year,
   input  logic [31:0] req_now_ms,
   input  logic [16:0] req_slot_time_in,
   input  logic [15:0] req_dose_in,
   input  logic [15:0] req_rate_in,
   input  logic [3:0]  req_count_in,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [1:0]  rsp_pump_out,
   output logic [15:0] rsp_run_seconds,
   output logic [16:0] rsp_next_run_sec,
   output logic        rsp_none_scheduled,
   output logic        rsp_last
);
   req_type req_item, cmd_item;
   rsp_type rsp_item;
   logic cmd_valid, cmd_take;

   assign req_item = '{action: req_action, pump: req_pump, slot: req_slot,
      now_sec: req_now_sec, day_of_year: req_day_of_year, now_ms: req_now_ms,
      slot_time_in: req_slot_time_in, dose_in: req_dose_in, rate_in: req_rate_in,
      count_in: req_count_in};

   ddas_front u_front (.clock, .reset, .push, .full, .req_item,
      .cmd_valid, .cmd_take, .cmd_item);

   ddas_back #(.PUMP_COUNT(PUMP_COUNT), .SLOTS_PER_PUMP(SLOTS_PER_PUMP)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_item, .empty, .pop, .rsp_item);

   assign rsp_kind = rsp_item.kind;
   assign rsp_pump_out = rsp_item.pump_out;
   assign rsp_run_seconds = rsp_item.run_seconds;
   assign rsp_next_run_sec = rsp_item.next_run_sec;
   assign rsp_none_scheduled = rsp_item.none_scheduled;
   assign rsp_last = rsp_item.last;
endmodule

// ----- tb/tb_daily_dose_alarm_scheduler_core.sv -----
// self-checking bench for the daily dose alarm scheduler core: random and directed
// ticks, table loads and next-run queries against an internal schedule predictor
// depends on ddas_pkg and daily_dose_alarm_scheduler_core
module tb_daily_dose_alarm_scheduler_core import ddas_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PUMPS = 4;
   localparam int SLOTS = 8;

   int error_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   class dose_scoreboard;
      logic [16:0] slot_time [PUMPS*SLOTS];
      logic [15:0] slot_dose [PUMPS*SLOTS];
      logic [15:0] pump_rate [PUMPS];
      logic [3:0]  active_count [PUMPS];
      logic [8:0]  fired_day [PUMPS*SLOTS];
      logic [31:0] fired_ms [PUMPS*SLOTS];
      rsp_type     pending [$];
      int          checked = 0;

      function new();
         for (int i = 0; i < PUMPS*SLOTS; i++) begin
            slot_time[i] = '0;
            slot_dose[i] = '0;
            fired_day[i] = NEVER_DAY;
            fired_ms[i] = '0;
         end
         for (int p = 0; p < PUMPS; p++) begin
            pump_rate[p] = 16'd1;
            active_count[p] = '0;
         end
      endfunction

      function automatic int used(input int p);
         return active_count[p] > SLOTS ? SLOTS : active_count[p];
      endfunction

      function automatic void note_item(input req_type r);
         int n;
         int idx;
         int cnt;
         logic [31:0] rate;
         logic [31:0] run;
         logic [31:0] best;
         logic [31:0] earliest;
         logic [31:0] back;
         logic [31:0] due;
         bit found;
         rsp_type o;
         n = 0;
         case (r.action)
            ACT_TICK: begin
               for (int p = 0; p < PUMPS; p++) begin
                  rate = pump_rate[p] == 0 ? 32'd1 : 32'(pump_rate[p]);
                  for (int t = 0; t < used(p); t++) begin
                     idx = p*SLOTS + t;
                     if (slot_time[idx] != r.now_sec) continue;
                     if (fired_day[idx] == r.day_of_year &&
                         (r.now_ms - fired_ms[idx]) < GUARD_MS) continue;
                     run = (32'(slot_dose[idx]) + rate - 1) / rate;
                     if (run != 0) begin
                        o = '0;
                        o.pump_out = p[1:0];
                        o.run_seconds = run[15:0];
                        pending.push_back(o);
                        n++;
                     end
                     fired_day[idx] = r.day_of_year;
                     fired_ms[idx] = r.now_ms;
                  end
               end
               if (n > 0) pending[$].last = 1'b1;
            end
            ACT_SLOT: begin
               slot_time[r.pump*SLOTS + r.slot] = r.slot_time_in;
               slot_dose[r.pump*SLOTS + r.slot] = r.dose_in;
            end
            ACT_PUMP: begin
               pump_rate[r.pump] = r.rate_in;
               active_count[r.pump] = r.count_in;
            end
            default: begin
               o = '0;
               o.kind = 1'b1;
               o.pump_out = r.pump;
               o.last = 1'b1;
               cnt = used(r.pump);
               if (cnt == 0) begin
                  o.none_scheduled = 1'b1;
               end else begin
                  found = 0;
                  best = 0;
                  earliest = 32'h1FFFF;
                  for (int t = 0; t < cnt; t++) begin
                     due = 32'(slot_time[r.pump*SLOTS + t]);
                     if (due < earliest) earliest = due;
                     if (due >= r.now_sec && (!found || due - r.now_sec < best)) begin
                        best = due - r.now_sec;
                        found = 1;
                     end
                  end
                  if (!found) begin
                     back = 32'(r.now_sec) - earliest;
                     best = back >= 86400 ? 0 : 86400 - back;
                  end
                  o.next_run_sec = best[16:0];
               end
               pending.push_back(o);
            end
         endcase
      endfunction

      task automatic check_result(input rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
         end
         want = pending.pop_front();
         if (got.kind != want.kind) report_mismatch($sformatf("kind %0d want %0d",
            got.kind, want.kind));
         if (got.pump_out != want.pump_out) report_mismatch($sformatf("pump %0d want %0d",
            got.pump_out, want.pump_out));
         if (got.run_seconds != want.run_seconds) report_mismatch($sformatf(
            "run_seconds %0d want %0d", got.run_seconds, want.run_seconds));
         if (got.next_run_sec != want.next_run_sec) report_mismatch($sformatf(
            "next_run_sec %0d want %0d", got.next_run_sec, want.next_run_sec));
         if (got.none_scheduled != want.none_scheduled) report_mismatch($sformatf(
            "none_scheduled %0d want %0d", got.none_scheduled, want.none_scheduled));
         if (got.last != want.last) report_mismatch($sformatf("last %0d want %0d",
            got.last, want.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   req_type req = '0;
   rsp_type rsp;
   int send_idle = 15;
   int recv_idle = 47;
   int sent = 0;
   bit recv_on = 0;
   int cur_sec = 1000;
   int cur_day = 10;
   logic [31:0] cur_ms = 32'd5000;
   dose_scoreboard sb = new();

   always #5 clock = ~clock;

   daily_dose_alarm_scheduler_core u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req.action), .req_pump(req.pump), .req_slot(req.slot),
      .req_now_sec(req.now_sec), .req_day_of_year(req.day_of_year),
      .req_now_ms(req.now_ms), .req_slot_time_in(req.slot_time_in),
      .req_dose_in(req.dose_in), .req_rate_in(req.rate_in),
      .req_count_in(req.count_in),
      .empty(empty), .pop(pop), .rsp_kind(rsp.kind), .rsp_pump_out(rsp.pump_out),
      .rsp_run_seconds(rsp.run_seconds), .rsp_next_run_sec(rsp.next_run_sec),
      .rsp_none_scheduled(rsp.none_scheduled), .rsp_last(rsp.last)
   );

   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_result(rsp);
      pop <= recv_on && ($urandom_range(99) >= recv_idle);
   end

   task automatic send_item(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_item(r);
      sent++;
   endtask

   task automatic drain;
      push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic req_type rand_fields();
      req_type r;
      r = '0;
      r.action = 2'($urandom_range(3));
      r.pump = 2'($urandom_range(3));
      r.slot = 3'($urandom_range(7));
      r.now_sec = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(86399));
      r.day_of_year = 9'($urandom);
      r.now_ms = $urandom;
      r.slot_time_in = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(86399));
      r.dose_in = 16'($urandom);
      r.rate_in = 16'($urandom);
      r.count_in = 4'($urandom);
      return r;
   endfunction

   function automatic req_type mk(input logic [1:0] a, input int p, input int s,
                                  input int t, input int d, input int rt, input int c);
      req_type r;
      r = '0;
      r.action = a; r.pump = 2'(p); r.slot = 3'(s);
      r.slot_time_in = 17'(t); r.dose_in = 16'(d); r.rate_in = 16'(rt);
      r.count_in = 4'(c);
      r.now_sec = 17'(t); r.day_of_year = 9'(cur_day); r.now_ms = cur_ms;
      return r;
   endfunction

   // mostly well-formed scheduling: slots near the running clock, ticks that hit them
   function automatic req_type next_item();
      req_type r;
      int k;
      r = rand_fields();
      k = $urandom_range(99);
      if (k < 85) begin
         r.slot_time_in = 17'(cur_sec + $urandom_range(3));
         if (r.action == ACT_PUMP) r.count_in = 4'($urandom_range(8));
         if (r.action == ACT_PUMP && $urandom_range(3) == 0)
            r.rate_in = 16'($urandom_range(50));
         if (r.action == ACT_TICK || $urandom_range(1)) begin
            r.action = ($urandom_range(2) == 0) ? ACT_SLOT : ACT_TICK;
            if (r.action == ACT_TICK) begin
               cur_sec = cur_sec + $urandom_range(1);
               cur_ms = cur_ms + $urandom_range(2) * 1000 + $urandom_range(999);
               if ($urandom_range(15) == 0) cur_day = $urandom_range(511);
               r.now_sec = 17'(cur_sec);
               r.day_of_year = 9'(cur_day);
               r.now_ms = cur_ms;
            end
         end
      end
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      recv_on <= 1'b1;
      @(posedge clock);
      // directed: empty queries, field extremes, zero rate, zero dose, guard, wrap
      send_item(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
      send_item(mk(ACT_PUMP, 0, 0, 0, 0, 0, 15));
      send_item(mk(ACT_SLOT, 0, 0, 100, 65535, 0, 0));
      send_item(mk(ACT_SLOT, 0, 7, 86399, 0, 0, 0));
      send_item(mk(ACT_SLOT, 0, 1, 100, 0, 0, 0));
      send_item(mk(ACT_SLOT, 0, 2, 131071, 1, 0, 0));
      send_item(mk(ACT_TICK, 0, 0, 100, 0, 0, 0));
      send_item(mk(ACT_TICK, 0, 0, 100, 0, 0, 0));
      cur_ms = cur_ms + 3000;
      send_item(mk(ACT_TICK, 0, 0, 100, 0, 0, 0));
      send_item(mk(ACT_QUERY, 0, 0, 50, 0, 0, 0));
      send_item(mk(ACT_QUERY, 0, 0, 131071, 0, 0, 0));
      send_item(mk(ACT_PUMP, 3, 0, 0, 0, 65535, 8));
      for (int s = 0; s < 8; s++) send_item(mk(ACT_SLOT, 3, s, 200, 65535, 0, 0));
      for (int p = 1; p < 3; p++) begin
         send_item(mk(ACT_PUMP, p, 0, 0, 0, 1, 8));
         for (int s = 0; s < 8; s++) send_item(mk(ACT_SLOT, p, s, 200, 1 + s, 0, 0));
      end
      r = mk(ACT_TICK, 0, 0, 200, 0, 0, 0);
      r.day_of_year = 511;
      r.now_ms = 32'hFFFF_FFFF;
      send_item(r);
      send_item(mk(ACT_QUERY, 3, 0, 86399, 0, 0, 0));
      drain();
      // random phases with swapped idling and a pause for a full drain
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = ph == 0 ? 15 : ph == 1 ? 47 : 0;
         recv_idle = ph == 0 ? 47 : ph == 1 ? 15 : 0;
         for (int i = 0; i < 75; i++) begin
            send_item(next_item());
            if (i == 37) drain();
         end
      end
      drain();
      $display("sent %0d items, checked %0d results over ticks, loads and queries",
               sent, sb.checked);
      if (error_count == 0 && sb.pending.size() == 0)
         $display("tb_daily_dose_alarm_scheduler_core: clean");
      else
         $display("tb_daily_dose_alarm_scheduler_core: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_daily_dose_alarm_scheduler_core: errors");
      $finish;
   end
endmodule
